@@ hw/rtl/sliding_window_latency_trend_estimator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the latency trend estimator
// Immediate-implication and next-cycle-implication checks on the clock.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_LATENCY_TREND_ESTIMATOR_TOP_ASSERT_SVH
`define SLIDING_WINDOW_LATENCY_TREND_ESTIMATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SWLTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SWLTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/swlte_pkg.sv @@
// ----------------------------------------------------------------------------
// swlte_pkg
// Shared constants, types and command/status bundles of the trend estimator.
// ----------------------------------------------------------------------------
package swlte_pkg;

	// Window and field widths
	localparam int unsigned WINDOW_SIZE = 16;
	localparam int unsigned COST_W      = 16;
	localparam int unsigned LOAD_W      = 16;
	localparam int unsigned EST_W       = 32;
	localparam int unsigned IDX_W       = $clog2(WINDOW_SIZE);
	localparam int unsigned CNT_W       = $clog2(WINDOW_SIZE + 1);
	localparam int unsigned SUM_W       = COST_W + IDX_W;
	localparam int unsigned NUM_W       = COST_W + 2 * IDX_W + 2;
	localparam int unsigned SLOPE_SHIFT = 6;

	// Mean divider: two quotient bits per cycle
	localparam int unsigned DIV_W      = ((SUM_W + 1) / 2) * 2;
	localparam int unsigned DIV_STEPS  = DIV_W / 2;
	localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(WINDOW_SIZE);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_SIZE - 1);

	// Centre of the x axis, truncated
	localparam logic signed [IDX_W:0] X_MID = (IDX_W+1)'((WINDOW_SIZE - 1) / 2);

	localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
	localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

	// Least-squares denominator with the integer approximations
	function automatic longint slope_den();
		longint xn;
		longint den;
		xn  = longint'(WINDOW_SIZE) - 1;
		den = longint'(WINDOW_SIZE) * ((xn * xn) / 4);
		for (longint i = 0; i < longint'(WINDOW_SIZE); i++) begin
			den += i * (i - xn);
		end
		return den;
	endfunction

	localparam longint             SLOPE_DEN = slope_den();
	localparam bit                 DEN_ZERO  = (SLOPE_DEN == 0);

	// Largest numerator magnitude: full-scale deviation at every x
	function automatic longint num_mag_max();
		longint xa;
		longint tot;
		xa  = (longint'(WINDOW_SIZE) - 1) / 2;
		tot = 0;
		for (longint i = 0; i < longint'(WINDOW_SIZE); i++) begin
			tot += (i < xa) ? (xa - i) : (i - xa);
		end
		return tot * ((longint'(1) << COST_W) - 1);
	endfunction

	// Slope division by the constant denominator as a reciprocal multiply:
	// quotient bits plus denominator bits of shift keep the floor exact
	localparam longint      NUM_MAG_MAX = num_mag_max();
	localparam int unsigned MAG_W       = $clog2(NUM_MAG_MAX + 1);
	localparam int unsigned QUO_W       = MAG_W + SLOPE_SHIFT;
	localparam int unsigned DEN_W       = $clog2(SLOPE_DEN);
	localparam int unsigned RECIP_SHIFT = QUO_W + DEN_W;

	function automatic longint slope_recip();
		longint pw;
		pw = longint'(1) << RECIP_SHIFT;
		if (SLOPE_DEN <= 0) begin
			return 0;
		end
		return (pw + SLOPE_DEN - 1) / SLOPE_DEN;
	endfunction

	localparam longint             RECIP_VAL = slope_recip();
	localparam int unsigned        RECIP_W   = $clog2(RECIP_VAL + 1) + 1;
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_VAL);

	// Slope and product widths
	localparam int unsigned SLOPE_W = QUO_W + 1;
	localparam int unsigned MULT_W  = LOAD_W + 1;
	localparam int unsigned PROD_W  = SLOPE_W + MULT_W + 1;

	// Item operation codes
	typedef enum logic {
		OP_DONE = 1'b0,
		OP_NEW  = 1'b1
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic     accept;
		logic     update;
		logic     div_start;
		logic     mean_load;
		logic     walk_init;
		logic     walk;
		logic     quo_load;
		logic     slope_load;
		logic     mul_load;
		logic     out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic div_done;
		logic div_busy;
		logic walk_done;
	} sts_t;

endpackage

@@ hw/rtl/swlte_in_if.sv @@
// ----------------------------------------------------------------------------
// swlte_in_if
// Input channel: completion or new-request event, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swlte_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [swlte_pkg::COST_W-1:0]  cost;

	modport source (output valid, op, cost, input ready);
	modport sink   (input valid, op, cost, output ready);
endinterface

@@ hw/rtl/swlte_out_if.sv @@
// ----------------------------------------------------------------------------
// swlte_out_if
// Result channel: estimated delay and average cost, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swlte_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [swlte_pkg::EST_W-1:0]  estimated_delay;
	logic [swlte_pkg::COST_W-1:0]        average_cost;

	modport source (output valid, estimated_delay, average_cost, input ready);
	modport sink   (input valid, estimated_delay, average_cost, output ready);
endinterface

@@ hw/rtl/swlte_div.sv @@
// ----------------------------------------------------------------------------
// swlte_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module swlte_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [swlte_pkg::DIV_W-1:0]    dividend,
	input  logic [swlte_pkg::DIV_W-1:0]    divisor,
	output logic [swlte_pkg::DIV_W-1:0]    quotient,
	output logic                           done,
	output logic                           busy
);

	logic [swlte_pkg::DIV_W:0]          rem_q;
	logic [swlte_pkg::DIV_W-1:0]        quo_q;
	logic [swlte_pkg::DIV_W-1:0]        dvs_q;
	logic [swlte_pkg::STEP_CNT_W-1:0]   cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [swlte_pkg::DIV_W:0]          rem_n;
	logic [swlte_pkg::DIV_W-1:0]        quo_n;

	// Two shift/compare/subtract steps
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		for (int k = 0; k < 2; k++) begin
			rem_n = {rem_n[swlte_pkg::DIV_W-1:0], quo_n[swlte_pkg::DIV_W-1]};
			quo_n = {quo_n[swlte_pkg::DIV_W-2:0], 1'b0};
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_n    = rem_n - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	// Step counter and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= swlte_pkg::STEP_CNT_W'(swlte_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == swlte_pkg::STEP_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
	assign busy     = busy_q;

endmodule

@@ hw/rtl/swlte_dp.sv @@
// ----------------------------------------------------------------------------
// swlte_dp
// Datapath: sample ring, running sum, load counter, slope accumulation,
// mean divider, reciprocal slope scaling, load multiply and output registers.
// ----------------------------------------------------------------------------
module swlte_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swlte_pkg::cmd_t                      cmd,
	output swlte_pkg::sts_t                      sts,
	input  logic                                 item_op,
	input  logic [swlte_pkg::COST_W-1:0]         item_cost,
	output logic signed [swlte_pkg::EST_W-1:0]   est,
	output logic [swlte_pkg::COST_W-1:0]         avg
);

	// Captured item
	swlte_pkg::op_t                      op_q;
	logic [swlte_pkg::COST_W-1:0]        cost_q;

	// Window state
	logic [swlte_pkg::COST_W-1:0]        ring_mem [swlte_pkg::WINDOW_SIZE];
	logic [swlte_pkg::WINDOW_SIZE-1:0]   vld_q;
	logic [swlte_pkg::IDX_W-1:0]         wp_q;
	logic [swlte_pkg::CNT_W-1:0]         fill_q;
	logic [swlte_pkg::SUM_W-1:0]         sum_q;
	logic [swlte_pkg::COST_W-1:0]        mean_q;
	logic [swlte_pkg::LOAD_W-1:0]        load_q;

	// Ring read port
	logic [swlte_pkg::IDX_W-1:0]         rd_addr;
	logic                                rd_en;
	logic                                wr_en;
	logic [swlte_pkg::COST_W-1:0]        rdata_s1;
	logic                                rhit_s1;
	logic [swlte_pkg::COST_W-1:0]        old_cost;

	// Window walk
	logic [swlte_pkg::IDX_W-1:0]         rd_q;
	logic [swlte_pkg::CNT_W-1:0]         iss_q;
	logic                                issue;
	logic                                rv_s1;
	logic [swlte_pkg::IDX_W-1:0]         ci_s1;
	logic signed [swlte_pkg::IDX_W:0]    coef;
	logic signed [swlte_pkg::COST_W:0]   diff;
	logic signed [swlte_pkg::IDX_W+swlte_pkg::COST_W+1:0] term;
	logic signed [swlte_pkg::NUM_W-1:0]  acc_q;
	logic [swlte_pkg::MAG_W-1:0]         acc_mag;

	// Mean divider
	logic [swlte_pkg::DIV_W-1:0]         dvd;
	logic [swlte_pkg::DIV_W-1:0]         dvs;
	logic [swlte_pkg::DIV_W-1:0]         quo;
	logic                                div_done;
	logic                                div_busy;

	// Slope by reciprocal
	logic [swlte_pkg::MAG_W+swlte_pkg::RECIP_W-1:0] rprod;
	logic [swlte_pkg::QUO_W-1:0]          mag_q;
	logic                                 neg_q;

	// Estimate
	logic signed [swlte_pkg::SLOPE_W-1:0] slope_q;
	logic [swlte_pkg::MULT_W-1:0]         load_p1;
	logic signed [swlte_pkg::PROD_W-1:0]  prod_q;
	logic signed [swlte_pkg::PROD_W:0]    est_sum;
	logic signed [swlte_pkg::EST_W-1:0]   est_sat;
	logic signed [swlte_pkg::EST_W-1:0]   est_q;
	logic [swlte_pkg::COST_W-1:0]         avg_q;

	function automatic logic [swlte_pkg::IDX_W-1:0] next_idx(
		input logic [swlte_pkg::IDX_W-1:0] idx
	);
		return (idx == swlte_pkg::LAST_IDX) ? '0 : idx + 1'b1;
	endfunction

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= swlte_pkg::op_t'(item_op);
			cost_q <= item_cost;
		end
	end

	// Ring memory, one read and one write port, registered read
	assign issue   = cmd.walk && (iss_q != swlte_pkg::FULL_CNT);
	assign rd_addr = cmd.walk ? rd_q : wp_q;
	assign rd_en   = cmd.accept || issue;
	assign wr_en   = cmd.update && (op_q == swlte_pkg::OP_DONE);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= ring_mem[rd_addr];
			rhit_s1  <= vld_q[rd_addr];
		end
		if (wr_en) begin
			ring_mem[wp_q] <= cost_q;
		end
	end

	// An entry never written reads as zero
	assign old_cost = rhit_s1 ? rdata_s1 : '0;

	// Window bookkeeping and load counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			mean_q <= '0;
			load_q <= '0;
		end else begin
			if (cmd.update) begin
				if (op_q == swlte_pkg::OP_DONE) begin
					vld_q[wp_q] <= 1'b1;
					wp_q        <= next_idx(wp_q);
					sum_q       <= sum_q - swlte_pkg::SUM_W'(old_cost)
					               + swlte_pkg::SUM_W'(cost_q);
					if (fill_q != swlte_pkg::FULL_CNT) begin
						fill_q <= fill_q + 1'b1;
					end
					if (load_q != '0) begin
						load_q <= load_q - 1'b1;
					end
				end else if (load_q != swlte_pkg::LOAD_MAX) begin
					load_q <= load_q + 1'b1;
				end
			end
			if (cmd.mean_load) begin
				mean_q <= quo[swlte_pkg::COST_W-1:0];
			end
		end
	end

	// Walk control: oldest sample first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			iss_q <= '0;
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (cmd.walk_init) begin
				rd_q  <= wp_q;
				iss_q <= '0;
			end else if (issue) begin
				rd_q  <= next_idx(rd_q);
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ci_s1 <= iss_q[swlte_pkg::IDX_W-1:0];
		end
	end

	// Numerator accumulation
	assign coef = $signed({1'b0, ci_s1}) - swlte_pkg::X_MID;
	assign diff = $signed({1'b0, old_cost}) - $signed({1'b0, mean_q});
	assign term = coef * diff;

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			acc_q <= '0;
		end else if (rv_s1) begin
			acc_q <= acc_q + swlte_pkg::NUM_W'(term);
		end
	end

	assign acc_mag = acc_q[swlte_pkg::NUM_W-1] ? swlte_pkg::MAG_W'(-acc_q)
	                                           : swlte_pkg::MAG_W'(acc_q);

	// Mean divider operands
	assign dvd = swlte_pkg::DIV_W'(sum_q);
	assign dvs = swlte_pkg::DIV_W'(fill_q);

	swlte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done),
		.busy     (div_busy)
	);

	// Slope magnitude: 64 * |num| / den through the reciprocal, floored
	assign rprod = acc_mag * swlte_pkg::RECIP;

	always_ff @(posedge clk) begin
		if (cmd.quo_load) begin
			mag_q <= swlte_pkg::QUO_W'(rprod >>
			         (swlte_pkg::RECIP_SHIFT - swlte_pkg::SLOPE_SHIFT));
			neg_q <= acc_q[swlte_pkg::NUM_W-1];
		end
	end

	// Signed slope, truncated toward zero
	always_ff @(posedge clk) begin
		if (cmd.slope_load) begin
			if (swlte_pkg::DEN_ZERO) begin
				slope_q <= '0;
			end else if (neg_q) begin
				slope_q <= -$signed({1'b0, mag_q});
			end else begin
				slope_q <= $signed({1'b0, mag_q});
			end
		end
	end

	// Scale by load plus one
	assign load_p1 = {1'b0, load_q} + swlte_pkg::MULT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			prod_q <= slope_q * $signed({1'b0, load_p1});
		end
	end

	// Floor shift, add mean and saturate
	assign est_sum = (swlte_pkg::PROD_W+1)'($signed({1'b0, mean_q}))
	               + (swlte_pkg::PROD_W+1)'(prod_q >>> swlte_pkg::SLOPE_SHIFT);

	always_comb begin
		priority if (est_sum > swlte_pkg::EST_MAX) begin
			est_sat = swlte_pkg::EST_MAX;
		end else if (est_sum < swlte_pkg::EST_MIN) begin
			est_sat = swlte_pkg::EST_MIN;
		end else begin
			est_sat = est_sum[swlte_pkg::EST_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			est_q <= (fill_q == swlte_pkg::FULL_CNT) ? est_sat
			                                         : swlte_pkg::EST_W'(mean_q);
			avg_q <= mean_q;
		end
	end

	assign est = est_q;
	assign avg = avg_q;

	// Status
	assign sts.op        = op_q;
	assign sts.full      = (fill_q == swlte_pkg::FULL_CNT);
	assign sts.div_done  = div_done;
	assign sts.div_busy  = div_busy;
	assign sts.walk_done = (iss_q == swlte_pkg::FULL_CNT) && !rv_s1;

endmodule

@@ hw/rtl/swlte_ctrl.sv @@
// ----------------------------------------------------------------------------
// swlte_ctrl
// Controller: sequences update, mean division, window walk, slope scaling,
// load multiply and result transfer.
// ----------------------------------------------------------------------------
module swlte_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  swlte_pkg::sts_t  sts,
	output swlte_pkg::cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_UPD    = 10'b00_0000_0010,
		S_MSTART = 10'b00_0000_0100,
		S_MWAIT  = 10'b00_0000_1000,
		S_WINIT  = 10'b00_0001_0000,
		S_WALK   = 10'b00_0010_0000,
		S_QUO    = 10'b00_0100_0000,
		S_SLOPE  = 10'b00_1000_0000,
		S_MUL    = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_vld_q;
	logic   room;

	// Output register is free or being emptied this cycle
	assign room = !out_vld_q || out_ready;

	// Next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				if (sts.op == swlte_pkg::OP_DONE) begin
					state_n = S_MSTART;
				end else begin
					state_n = sts.full ? S_WINIT : S_DONE;
				end
			end
			S_MSTART: begin
				cmd.div_start = 1'b1;
				state_n       = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.div_done) begin
					cmd.mean_load = 1'b1;
					state_n       = sts.full ? S_WINIT : S_DONE;
				end
			end
			S_WINIT: begin
				cmd.walk_init = 1'b1;
				state_n       = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_n = S_QUO;
				end
			end
			S_QUO: begin
				cmd.quo_load = 1'b1;
				state_n      = S_SLOPE;
			end
			S_SLOPE: begin
				cmd.slope_load = 1'b1;
				state_n        = S_MUL;
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_n      = S_DONE;
			end
			S_DONE: begin
				if (room) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

endmodule

@@ hw/rtl/sliding_window_latency_trend_estimator_top.sv @@
// Each item is updated into the window; a completion then has the mean divided, and with a
// full window either kind of event then runs the window walk, slope scaling and load multiply
// before the result register is loaded, which waits while an earlier result is untransferred.
// Only one item is in work: the next is taken in the cycle after the result register loads.
// Time goes to the window walk (one sample a cycle) and the two-bit-per-cycle mean divider.
// Reset (arst_n low, asynchronous) empties the window and clears sum, mean and load.
// ----------------------------------------------------------------------------
// sliding_window_latency_trend_estimator_top
// Moving average of request cost with a least-squares trend scaled by load.
// ----------------------------------------------------------------------------
`include "sliding_window_latency_trend_estimator_top_assert.svh"

module sliding_window_latency_trend_estimator_top (
	input  logic          clk,
	input  logic          arst_n,
	swlte_in_if.sink      item,
	swlte_out_if.source   result
);

	swlte_pkg::cmd_t cmd;
	swlte_pkg::sts_t sts;

	swlte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	swlte_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item_op   (item.op),
		.item_cost (item.cost),
		.est       (result.estimated_delay),
		.avg       (result.average_cost)
	);

	// One item in flight: no transfer in the cycle after an accepted item
	`SWLTE_ASSERT_NEXT(a_one_in_flight, clk, arst_n, item.valid && item.ready, !item.ready, "item taken while previous still in work")

	// A finished result never overwrites one not yet transferred
	`SWLTE_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, !result.valid || result.ready, "result register overwritten")

	// Divider is never restarted mid-division
	`SWLTE_ASSERT_SAME(a_div_idle_on_start, clk, arst_n, cmd.div_start, !sts.div_busy, "divider restarted while busy")

	// The slope walk only runs over a full window
	`SWLTE_ASSERT_SAME(a_walk_full, clk, arst_n, cmd.walk_init, sts.full, "window walk started before window full")

endmodule
